>>> rtl/gyro_rate_smoother_integrator_core_macros.svh
// Assertion macros shared by the gyro smoother RTL.
// Each macro checks an implication on the rising clock edge, outside reset.
`ifndef GYRO_RATE_SMOOTHER_INTEGRATOR_CORE_MACROS_SVH
`define GYRO_RATE_SMOOTHER_INTEGRATOR_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define GRSI_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grsi assertion failed");
// Next-cycle implication.
`define GRSI_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grsi assertion failed");
`else
`define GRSI_ASSERT_NOW(name, clk, rst_n, ante, cons)
`define GRSI_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/grsi_pkg.sv
package grsi_pkg;

    // Default accumulator width
    localparam int VALUE_WIDTH_DEF = 32;

    // Shared multiplier: 64-bit A by 34-bit B, two 32-bit slices of A
    localparam int MUL_A_W = 64;
    localparam int MUL_B_W = 34;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Opcodes
    localparam logic [1:0] OP_SAMPLE  = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_ENABLE = 2'd0;
    localparam logic [1:0] CFG_SENS   = 2'd1;
    localparam logic [1:0] CFG_DZONE  = 2'd2;

    // Arithmetic constants
    localparam logic [31:0] K_DEG_NS    = 32'd4128596019;  // deg per ns, Q56
    localparam logic [62:0] DT_MAX_NS   = 63'd500000000;
    localparam logic [28:0] DT_CAP_NS   = 29'd2142934;     // base alpha saturates here
    localparam logic [36:0] BASE_RECIP  = 37'd92233720369; // ceil(2^56 / 781250)
    localparam logic [41:0] BASE_MUL    = 42'd7168;
    localparam logic [41:0] BASE_OFS    = 42'd390625;
    localparam logic [14:0] ALPHA_MIN   = 15'd7864;
    localparam logic [14:0] ALPHA_MAX   = 15'd19661;
    localparam logic [17:0] ALPHA_CAP   = 18'd55706;
    localparam logic [17:0] MAG_CAP     = 18'd200000;
    localparam logic [39:0] FIFTH_RECIP = 40'd838861;      // ceil(2^22 / 5)
    localparam logic [15:0] SENS_UNITY  = 16'd256;
    localparam logic [15:0] SENS_RESET  = 16'd256;
    localparam logic [15:0] DZONE_RESET = 16'd655;

    // Datapath step codes
    typedef logic [4:0] t_step;
    localparam t_step STEP_NONE     = 5'd0;
    localparam t_step STEP_CLEAR    = 5'd1;
    localparam t_step STEP_FIRST    = 5'd2;
    localparam t_step STEP_SKIP     = 5'd3;
    localparam t_step STEP_TAKE     = 5'd4;
    localparam t_step STEP_PREP     = 5'd5;
    localparam t_step STEP_MUL_YT   = 5'd6;
    localparam t_step STEP_MUL_YK   = 5'd7;
    localparam t_step STEP_MUL_YE   = 5'd8;
    localparam t_step STEP_MUL_PT   = 5'd9;
    localparam t_step STEP_MUL_PK   = 5'd10;
    localparam t_step STEP_MUL_PE   = 5'd11;
    localparam t_step STEP_MUL_BASE = 5'd12;
    localparam t_step STEP_ALPHA    = 5'd13;
    localparam t_step STEP_DIFF     = 5'd14;
    localparam t_step STEP_MUL_YB   = 5'd15;
    localparam t_step STEP_MUL_PB   = 5'd16;
    localparam t_step STEP_SUM      = 5'd17;
    localparam t_step STEP_OUT_ZERO = 5'd18;
    localparam t_step STEP_OUT_SUM  = 5'd19;

    // Controller to datapath
    typedef struct packed {
        logic  in_ready;
        logic  mul_start;
        t_step step;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       enable;
        logic       first;
        logic       dt_ok;
        logic       mul_done;
        logic       out_free;
    } t_stat;

endpackage

>>> rtl/grsi_mul.sv
module grsi_mul import grsi_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [MUL_A_W-1:0] i_a,
    input  logic [MUL_B_W-1:0] i_b,
    output logic               o_done,
    output logic [MUL_P_W-1:0] o_prod
);

    logic [31:0]        r_a_hi;
    logic [MUL_B_W-1:0] r_b;
    logic [MUL_P_W-1:0] r_acc;
    logic               r_pend;
    logic               r_done;
    logic [MUL_B_W+31:0] w_lo;
    logic [MUL_B_W+31:0] w_hi;

    // One 32 x 34 partial product per cycle
    assign w_lo = i_a[31:0] * i_b;
    assign w_hi = r_a_hi * r_b;

    // Control: low slice on start, high slice next, then flag done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_pend <= i_start;
            r_done <= r_pend;
        end
    end

    // Accumulate the partial products
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc  <= MUL_P_W'(w_lo);
            r_a_hi <= i_a[MUL_A_W-1:32];
            r_b    <= i_b;
        end else if (r_pend) begin
            r_acc <= r_acc + {w_hi, 32'b0};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

>>> rtl/grsi_ctrl.sv
module grsi_ctrl import grsi_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_PREP   = 4'd2;
    localparam logic [3:0] S_MYT    = 4'd3;
    localparam logic [3:0] S_MYK    = 4'd4;
    localparam logic [3:0] S_MYE    = 4'd5;
    localparam logic [3:0] S_MPT    = 4'd6;
    localparam logic [3:0] S_MPK    = 4'd7;
    localparam logic [3:0] S_MPE    = 4'd8;
    localparam logic [3:0] S_MBASE  = 4'd9;
    localparam logic [3:0] S_ALPHA  = 4'd10;
    localparam logic [3:0] S_DIFF   = 4'd11;
    localparam logic [3:0] S_MYB    = 4'd12;
    localparam logic [3:0] S_MPB    = 4'd13;
    localparam logic [3:0] S_SUM    = 4'd14;
    localparam logic [3:0] S_OUT    = 4'd15;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_started;
    logic       n_started;
    logic [3:0] w_mul_next;
    logic       w_is_mul;
    t_step      w_mul_step;

    // Map multiply states to their step and successor
    always_comb begin
        w_is_mul   = 1'b1;
        w_mul_step = STEP_NONE;
        w_mul_next = S_IDLE;
        case (r_state)
            S_MYT: begin
                w_mul_step = STEP_MUL_YT;
                w_mul_next = S_MYK;
            end
            S_MYK: begin
                w_mul_step = STEP_MUL_YK;
                w_mul_next = S_MYE;
            end
            S_MYE: begin
                w_mul_step = STEP_MUL_YE;
                w_mul_next = S_MPT;
            end
            S_MPT: begin
                w_mul_step = STEP_MUL_PT;
                w_mul_next = S_MPK;
            end
            S_MPK: begin
                w_mul_step = STEP_MUL_PK;
                w_mul_next = S_MPE;
            end
            S_MPE: begin
                w_mul_step = STEP_MUL_PE;
                w_mul_next = S_MBASE;
            end
            S_MBASE: begin
                w_mul_step = STEP_MUL_BASE;
                w_mul_next = S_ALPHA;
            end
            S_MYB: begin
                w_mul_step = STEP_MUL_YB;
                w_mul_next = S_MPB;
            end
            S_MPB: begin
                w_mul_step = STEP_MUL_PB;
                w_mul_next = S_SUM;
            end
            default: w_is_mul = 1'b0;
        endcase
    end

    // Next state and commands
    always_comb begin
        n_state         = r_state;
        n_started       = r_started;
        o_cmd.in_ready  = 1'b0;
        o_cmd.mul_start = 1'b0;
        o_cmd.step      = STEP_NONE;
        if (w_is_mul) begin
            // Issue once, then hold until the product is back
            o_cmd.step      = w_mul_step;
            o_cmd.mul_start = !r_started;
            n_started       = 1'b1;
            if (r_started && i_stat.mul_done) begin
                n_state   = w_mul_next;
                n_started = 1'b0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    o_cmd.in_ready = 1'b1;
                    if (i_in_valid) begin
                        n_state = S_DECODE;
                    end
                end
                S_DECODE: begin
                    n_state = S_IDLE;
                    if (!i_stat.enable) begin
                        o_cmd.step = STEP_CLEAR;
                        if (i_stat.op == OP_READ) begin
                            n_state = S_OUT;
                        end
                    end else begin
                        case (i_stat.op)
                            OP_SAMPLE: begin
                                if (i_stat.first) begin
                                    o_cmd.step = STEP_FIRST;
                                end else if (!i_stat.dt_ok) begin
                                    o_cmd.step = STEP_SKIP;
                                end else begin
                                    o_cmd.step = STEP_TAKE;
                                    n_state    = S_PREP;
                                end
                            end
                            OP_READ:    n_state = S_OUT;
                            OP_RESTART: o_cmd.step = STEP_CLEAR;
                            default:    n_state = S_IDLE;
                        endcase
                    end
                end
                S_PREP: begin
                    o_cmd.step = STEP_PREP;
                    n_state    = S_MYT;
                end
                S_ALPHA: begin
                    o_cmd.step = STEP_ALPHA;
                    n_state    = S_DIFF;
                end
                S_DIFF: begin
                    o_cmd.step = STEP_DIFF;
                    n_state    = S_MYB;
                end
                S_SUM: begin
                    o_cmd.step = STEP_SUM;
                    n_state    = S_IDLE;
                end
                S_OUT: begin
                    // Wait for the output slot to free up
                    if (i_stat.out_free) begin
                        o_cmd.step = i_stat.enable ? STEP_OUT_SUM : STEP_OUT_ZERO;
                        n_state    = S_IDLE;
                    end
                end
                default: n_state = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_started <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_started <= n_started;
        end
    end

endmodule

>>> rtl/grsi_dp.sv
module grsi_dp import grsi_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic               i_in_valid,
    input  logic [1:0]         i_opcode,
    input  logic [62:0]        i_stamp_ns,
    input  logic signed [31:0] i_rate_x,
    input  logic signed [31:0] i_rate_y,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_yaw_delta,
    output logic signed [31:0] o_pitch_delta
);

    localparam int VW  = VALUE_WIDTH;
    localparam int VW1 = VW + 1;
    localparam int VW2 = VW + 2;
    localparam int QW  = VW + 18;
    localparam logic [63:0] L_VMAX = (64'd1 << (VW - 1)) - 64'd1;
    localparam logic signed [VW-1:0] L_SMAX = {1'b0, {(VW - 1){1'b1}}};
    localparam logic signed [VW-1:0] L_SMIN = {1'b1, {(VW - 1){1'b0}}};

    // Saturate a two-bit-wider signed value to VW bits
    function automatic logic signed [VW-1:0] f_sat(input logic signed [VW+1:0] v);
        if (v[VW+1:VW-1] == {3{v[VW+1]}}) begin
            f_sat = v[VW-1:0];
        end else if (v[VW+1]) begin
            f_sat = L_SMIN;
        end else begin
            f_sat = L_SMAX;
        end
    endfunction

    // Saturate an accumulator to the 32-bit result
    function automatic logic [31:0] f_sat32(input logic signed [VW-1:0] v);
        logic signed [63:0] x;
        x = 64'(v);
        if (x > 64'sd2147483647) begin
            f_sat32 = 32'h7fff_ffff;
        end else if (x < -64'sd2147483648) begin
            f_sat32 = 32'h8000_0000;
        end else begin
            f_sat32 = x[31:0];
        end
    endfunction

    // Configuration
    logic        r_enable;
    logic [15:0] r_sens;
    logic [15:0] r_dz;

    // Latched item
    logic [1:0]         r_op;
    logic [62:0]        r_stamp;
    logic signed [31:0] r_rate_x;
    logic signed [31:0] r_rate_y;

    // Filter state
    logic [62:0]          r_last;
    logic                 r_first;
    logic signed [VW-1:0] r_smooth_y;
    logic signed [VW-1:0] r_smooth_p;
    logic signed [VW-1:0] r_sum_y;
    logic signed [VW-1:0] r_sum_p;

    // Working registers
    logic [28:0]          r_dt;
    logic [32:0]          r_expo;
    logic [33:0]          r_num;
    logic                 r_cap;
    logic [31:0]          r_mag_y;
    logic [31:0]          r_mag_p;
    logic                 r_neg_y;
    logic                 r_neg_p;
    logic                 r_dz_y;
    logic                 r_dz_p;
    logic [63:0]          r_t;
    logic signed [VW-1:0] r_sc_y;
    logic signed [VW-1:0] r_sc_p;
    logic [14:0]          r_base;
    logic [15:0]          r_alpha;
    logic [VW:0]          r_dm_y;
    logic [VW:0]          r_dm_p;
    logic                 r_dneg_y;
    logic                 r_dneg_p;

    // Output word
    logic        r_out_valid;
    logic [31:0] r_out_yaw;
    logic [31:0] r_out_pitch;

    // Multiplier
    logic [MUL_A_W-1:0] w_mul_a;
    logic [MUL_B_W-1:0] w_mul_b;
    logic               w_mul_done;
    logic [MUL_P_W-1:0] w_prod;

    // Time step check
    logic [62:0] w_dt_full;
    logic        w_dt_ok;

    // Prep
    logic        w_neg_y;
    logic [31:0] w_mag_y;
    logic [31:0] w_mag_p;
    logic [15:0] w_s;
    logic [31:0] w_ss;
    logic [32:0] w_expo;
    logic [41:0] w_num42;

    // Product post-processing
    logic [MUL_P_W-1:0]   w_r40;
    logic [MUL_P_W-1:0]   w_r34;
    logic [63:0]          w_e;
    logic [63:0]          w_ec;
    logic [VW-1:0]        w_sv;
    logic                 w_sel_neg;
    logic                 w_sel_dz;
    logic signed [VW-1:0] w_sc;
    logic [41:0]          w_q56;
    logic [14:0]          w_base;

    // Alpha
    logic [VW-1:0] w_ay;
    logic [VW-1:0] w_ap;
    logic [VW-1:0] w_am;
    logic [17:0]   w_am18;
    logic [18:0]   w_an;
    logic [39:0]   w_q5p;
    logic [17:0]   w_alpha18;
    logic [15:0]   w_alpha;

    // Difference and blend
    logic signed [VW:0]   w_dy;
    logic signed [VW:0]   w_dp;
    logic                 w_bneg;
    logic signed [VW-1:0] w_bold;
    logic signed [QW-1:0] w_bm;
    logic signed [QW-1:0] w_bq;
    logic signed [QW-1:0] w_bs;
    logic signed [VW+1:0] w_bnew;
    logic signed [VW+1:0] w_sy;
    logic signed [VW+1:0] w_sp;

    logic w_accept;
    logic w_out_take;

    grsi_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    assign w_accept   = i_cmd.in_ready && i_in_valid;
    assign w_out_take = r_out_valid && i_out_ready;

    // Step since the last sample
    assign w_dt_full = r_stamp - r_last;
    assign w_dt_ok   = (r_stamp > r_last) && (w_dt_full <= DT_MAX_NS);

    // Axis magnitudes, sensitivity expo, base alpha numerator
    assign w_neg_y = !r_rate_x[31] && (r_rate_x != 32'sd0);
    assign w_mag_y = r_rate_x[31] ? 32'(-r_rate_x) : r_rate_x;
    assign w_mag_p = r_rate_y[31] ? 32'(-r_rate_y) : r_rate_y;
    assign w_s     = (r_sens == 16'd0) ? SENS_UNITY : r_sens;
    assign w_ss    = 32'(w_s) * 32'(w_s);
    assign w_expo  = 33'({w_s, 10'b0}) + 33'(w_ss);
    assign w_num42 = 42'(r_dt) * BASE_MUL + BASE_OFS;

    // Select multiplier operands
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (i_cmd.step)
            STEP_MUL_YT: begin
                w_mul_a = MUL_A_W'(r_mag_y);
                w_mul_b = MUL_B_W'(r_dt);
            end
            STEP_MUL_PT: begin
                w_mul_a = MUL_A_W'(r_mag_p);
                w_mul_b = MUL_B_W'(r_dt);
            end
            STEP_MUL_YK, STEP_MUL_PK: begin
                w_mul_a = r_t;
                w_mul_b = MUL_B_W'(K_DEG_NS);
            end
            STEP_MUL_YE, STEP_MUL_PE: begin
                w_mul_a = r_t;
                w_mul_b = MUL_B_W'(r_expo);
            end
            STEP_MUL_BASE: begin
                w_mul_a = MUL_A_W'(BASE_RECIP);
                w_mul_b = r_num;
            end
            STEP_MUL_YB: begin
                w_mul_a = MUL_A_W'(r_dm_y);
                w_mul_b = MUL_B_W'(r_alpha);
            end
            STEP_MUL_PB: begin
                w_mul_a = MUL_A_W'(r_dm_p);
                w_mul_b = MUL_B_W'(r_alpha);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // Round the products and finish the scaled value
    assign w_r40     = w_prod + (MUL_P_W'(1) << 39);
    assign w_r34     = w_prod + (MUL_P_W'(1) << 33);
    assign w_e       = w_r34[MUL_P_W-1:34];
    assign w_ec      = (w_e > L_VMAX) ? L_VMAX : w_e;
    assign w_sv      = w_ec[VW-1:0];
    assign w_sel_neg = (i_cmd.step == STEP_MUL_YE) ? r_neg_y : r_neg_p;
    assign w_sel_dz  = (i_cmd.step == STEP_MUL_YE) ? r_dz_y : r_dz_p;
    assign w_sc      = w_sel_dz ? '0 : (w_sel_neg ? -$signed(w_sv) : $signed(w_sv));

    // Base alpha from the reciprocal product
    assign w_q56 = w_prod[MUL_P_W-1:56];
    always_comb begin
        if (r_cap || (w_q56 > 42'(ALPHA_MAX))) begin
            w_base = ALPHA_MAX;
        end else if (w_q56 < 42'(ALPHA_MIN)) begin
            w_base = ALPHA_MIN;
        end else begin
            w_base = w_q56[14:0];
        end
    end

    // Alpha = base + 0.4 * larger magnitude, capped
    assign w_ay      = r_sc_y[VW-1] ? VW'(-r_sc_y) : r_sc_y;
    assign w_ap      = r_sc_p[VW-1] ? VW'(-r_sc_p) : r_sc_p;
    assign w_am      = (w_ap > w_ay) ? w_ap : w_ay;
    assign w_am18    = (64'(w_am) > 64'(MAG_CAP)) ? MAG_CAP : 18'(w_am);
    assign w_an      = {w_am18, 1'b0} + 19'd2;
    assign w_q5p     = 40'(w_an) * FIFTH_RECIP;
    assign w_alpha18 = 18'(r_base) + w_q5p[39:22];
    assign w_alpha   = (w_alpha18 > ALPHA_CAP) ? ALPHA_CAP[15:0] : w_alpha18[15:0];

    // Distance from the smoothed value
    assign w_dy = VW1'(r_sc_y) - VW1'(r_smooth_y);
    assign w_dp = VW1'(r_sc_p) - VW1'(r_smooth_p);

    // Blend: old + floor((d * alpha + half) / 2^16)
    assign w_bneg = (i_cmd.step == STEP_MUL_YB) ? r_dneg_y : r_dneg_p;
    assign w_bold = (i_cmd.step == STEP_MUL_YB) ? r_smooth_y : r_smooth_p;
    assign w_bm   = $signed(w_prod[QW-1:0]);
    assign w_bq   = w_bneg ? -w_bm : w_bm;
    assign w_bs   = (w_bq + QW'(32768)) >>> 16;
    assign w_bnew = VW2'(w_bold) + $signed(w_bs[VW+1:0]);

    // Accumulate
    assign w_sy = VW2'(r_sum_y) + VW2'(r_smooth_y);
    assign w_sp = VW2'(r_sum_p) + VW2'(r_smooth_p);

    // Configuration, filter state and the output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_sens      <= SENS_RESET;
            r_dz        <= DZONE_RESET;
            r_last      <= '0;
            r_first     <= 1'b1;
            r_smooth_y  <= '0;
            r_smooth_p  <= '0;
            r_sum_y     <= '0;
            r_sum_p     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ENABLE: begin
                        r_enable <= i_cfg_data[0];
                        if (!i_cfg_data[0]) begin
                            r_last     <= '0;
                            r_first    <= 1'b1;
                            r_smooth_y <= '0;
                            r_smooth_p <= '0;
                            r_sum_y    <= '0;
                            r_sum_p    <= '0;
                        end
                    end
                    CFG_SENS:  r_sens <= i_cfg_data;
                    CFG_DZONE: r_dz   <= i_cfg_data;
                    default:   r_dz   <= r_dz;
                endcase
            end
            // Load a new word, or drop the one just taken
            if ((i_cmd.step == STEP_OUT_ZERO) || (i_cmd.step == STEP_OUT_SUM)) begin
                r_out_valid <= 1'b1;
            end else if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.step)
                STEP_CLEAR: begin
                    r_last     <= '0;
                    r_first    <= 1'b1;
                    r_smooth_y <= '0;
                    r_smooth_p <= '0;
                    r_sum_y    <= '0;
                    r_sum_p    <= '0;
                end
                STEP_FIRST: begin
                    r_last  <= r_stamp;
                    r_first <= 1'b0;
                end
                STEP_SKIP, STEP_TAKE: r_last <= r_stamp;
                STEP_MUL_YB: begin
                    if (w_mul_done) begin
                        r_smooth_y <= f_sat(w_bnew);
                    end
                end
                STEP_MUL_PB: begin
                    if (w_mul_done) begin
                        r_smooth_p <= f_sat(w_bnew);
                    end
                end
                STEP_SUM: begin
                    r_sum_y <= f_sat(w_sy);
                    r_sum_p <= f_sat(w_sp);
                end
                STEP_OUT_SUM: begin
                    r_sum_y <= '0;
                    r_sum_p <= '0;
                end
                default: ;
            endcase
        end
    end

    // Item latch and working registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= i_opcode;
            r_stamp  <= i_stamp_ns;
            r_rate_x <= i_rate_x;
            r_rate_y <= i_rate_y;
        end
        case (i_cmd.step)
            STEP_TAKE: r_dt <= w_dt_full[28:0];
            STEP_PREP: begin
                r_mag_y <= w_mag_y;
                r_mag_p <= w_mag_p;
                r_neg_y <= w_neg_y;
                r_neg_p <= r_rate_y[31];
                r_dz_y  <= w_mag_y < 32'(r_dz);
                r_dz_p  <= w_mag_p < 32'(r_dz);
                r_expo  <= w_expo;
                r_num   <= w_num42[33:0];
                r_cap   <= r_dt >= DT_CAP_NS;
            end
            STEP_MUL_YT, STEP_MUL_PT: begin
                if (w_mul_done) begin
                    r_t <= w_prod[63:0];
                end
            end
            STEP_MUL_YK, STEP_MUL_PK: begin
                if (w_mul_done) begin
                    r_t <= 64'(w_r40[MUL_P_W-1:40]);
                end
            end
            STEP_MUL_YE: begin
                if (w_mul_done) begin
                    r_sc_y <= w_sc;
                end
            end
            STEP_MUL_PE: begin
                if (w_mul_done) begin
                    r_sc_p <= w_sc;
                end
            end
            STEP_MUL_BASE: begin
                if (w_mul_done) begin
                    r_base <= w_base;
                end
            end
            STEP_ALPHA: r_alpha <= w_alpha;
            STEP_DIFF: begin
                r_dneg_y <= w_dy[VW];
                r_dneg_p <= w_dp[VW];
                r_dm_y   <= w_dy[VW] ? VW1'(-w_dy) : w_dy;
                r_dm_p   <= w_dp[VW] ? VW1'(-w_dp) : w_dp;
            end
            STEP_OUT_ZERO: begin
                r_out_yaw   <= '0;
                r_out_pitch <= '0;
            end
            STEP_OUT_SUM: begin
                r_out_yaw   <= f_sat32(r_sum_y);
                r_out_pitch <= f_sat32(r_sum_p);
            end
            default: ;
        endcase
    end

    // Status back to the controller
    assign o_stat.op       = r_op;
    assign o_stat.enable   = r_enable;
    assign o_stat.first    = r_first;
    assign o_stat.dt_ok    = w_dt_ok;
    assign o_stat.mul_done = w_mul_done;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_yaw_delta   = r_out_yaw;
    assign o_pitch_delta = r_out_pitch;

endmodule

>>> rtl/gyro_rate_smoother_integrator_core.sv
// Gyro rate smoother and integrator. Each input word is a sample (timestamp
// in ns plus X/Y rates in Q15.16 rad/s), a read-and-clear of the yaw/pitch
// degree accumulators, or a filter restart; only a read returns a word. A
// processed sample keeps the block busy until its update ends: nine products
// (rate by step, degree factor, sensitivity expo, base alpha reciprocal, two
// blends) pass one after another through a single 64 x 34 multiplier, plus
// setup and update steps. A sample that only latches its timestamp, a restart
// and an ignored opcode go back to idle after decode; a read loads the output
// register once it is free, else waits until its previous word is taken.
// Configuration is to be written by the user only while the block is idle;
// the block does not enforce this. Clearing enable resets all filter state.
`include "gyro_rate_smoother_integrator_core_macros.svh"

module gyro_rate_smoother_integrator_core import grsi_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_opcode,
    input  logic [62:0]        i_stamp_ns,
    input  logic signed [31:0] i_rate_x,
    input  logic signed [31:0] i_rate_y,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_yaw_delta,
    output logic signed [31:0] o_pitch_delta,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    grsi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    grsi_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_in_valid    (i_in_valid),
        .i_opcode      (i_opcode),
        .i_stamp_ns    (i_stamp_ns),
        .i_rate_x      (i_rate_x),
        .i_rate_y      (i_rate_y),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_yaw_delta   (o_yaw_delta),
        .o_pitch_delta (o_pitch_delta)
    );

    assign o_in_ready = w_cmd.in_ready;

    // A returning product only arrives while an item is in work
    `GRSI_ASSERT_NOW(a_done_busy, i_clk, i_rst_n, w_stat.mul_done, !o_in_ready)
    // An accepted word keeps the block busy in the next cycle
    `GRSI_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    // Never load a result over one that is still waiting
    `GRSI_ASSERT_NOW(a_out_free, i_clk, i_rst_n, (w_cmd.step == STEP_OUT_SUM) || (w_cmd.step == STEP_OUT_ZERO), w_stat.out_free)
    // A multiply is never issued while the block takes input
    `GRSI_ASSERT_NOW(a_start_busy, i_clk, i_rst_n, w_cmd.mul_start, !o_in_ready)

endmodule
